@@ rtl/load_hit_bimodal_predictor_macros.svh @@
// ---------------------------------------------------------------------------
// Load-hit bimodal predictor assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ---------------------------------------------------------------------------
`ifndef LOAD_HIT_BIMODAL_PREDICTOR_MACROS_SVH
`define LOAD_HIT_BIMODAL_PREDICTOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, held off while reset is asserted
`define LHBP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load_hit_bimodal_predictor: implication violated");
// Next-cycle implication, held off while reset is asserted
`define LHBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load_hit_bimodal_predictor: next-cycle implication violated");
`else
`define LHBP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define LHBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lhbp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_pkg
// Shared types and constants of the load-hit bimodal predictor.
// ---------------------------------------------------------------------------
package lhbp_pkg;

    // Table size; a power of two, so the entry index is the low hash bits
    localparam int TABLE_ENTRIES = 1024;

    // Default for the top-level parameter
    localparam int DEF_HISTORY_BITS  = 8;

    // Field and bus widths
    localparam int ADDR_W     = 64;
    localparam int HIST_OUT_W = 8;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;

    // Index hash: addr ^ (addr >> HASH_SHIFT)
    localparam int HASH_SHIFT = 10;

    // Two-bit saturating counter
    localparam logic [1:0] CTR_MAX     = 2'd3;
    localparam logic [1:0] CTR_MIN     = 2'd0;
    localparam logic [1:0] CTR_HIT_THR = 2'd2;
    localparam logic [1:0] CTR_RESET   = 2'd2;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_UPDATE  = 1'b1
    } t_opcode;

    // Per-request side band carried alongside the index
    typedef struct packed {
        t_opcode op;
        logic    hit;
    } t_tag;

    // Result; packed so that pred lands in bit 0 and hist above it
    typedef struct packed {
        logic [HIST_OUT_W-1:0] hist;
        logic                  pred;
    } t_result;

    // Output buffer occupancy
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_obuf_stat;

endpackage

@@ rtl/load_hit_bimodal_predictor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_hit_bimodal_predictor
// Predicts load cache hits from a table of two-bit saturating counters,
// with a per-entry outcome history, indexed by a hash of the address.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser: opcode; tdata: address, actual_hit
//  m_*       out  m_tvalid/m_tready    tdata: predict_hit, entry_history
//  i_cfg_*   in   i_cfg_wen            i_cfg_wdata: enable
//
// One request per cycle while the skid entry is free. A result reaches the output
// register through the input register with the hash, then the table read and
// update stage.
// After reset the table is swept once, with s_tready low.
// When m_tready is low one more result goes into the skid entry, then the whole
// pipeline stalls.
// ---------------------------------------------------------------------------
module load_hit_bimodal_predictor
    import lhbp_pkg::*;
#(
    parameter int HISTORY_BITS  = DEF_HISTORY_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: enable
    input  logic                 i_cfg_wen,
    input  logic                 i_cfg_wdata,
    // requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [63:0] load_address, [64] actual_hit
    input  logic                 s_tuser,   // [0] opcode
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] predict_hit, [8:1] entry_history
);

`include "load_hit_bimodal_predictor_macros.svh"

    localparam int IW     = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = HISTORY_BITS + 2;

    logic              r_enable;
    logic              r_clr_busy;
    logic [IW-1:0]     r_clr_idx;

    logic              adv;
    t_obuf_stat        obuf_stat;
    logic              in_valid;
    t_tag              in_tag;

    logic              hm_valid;
    logic [IW-1:0]     hm_idx;
    t_tag              hm_tag;

    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    logic              tr_we;
    logic [IW-1:0]     tr_waddr;
    logic [WORD_W-1:0] tr_wdata;
    logic              res_valid;
    t_result           res;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_wen) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == IW'(TABLE_ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // Accept while the skid entry is free and the sweep is done
    assign s_tready  = adv && !r_clr_busy;
    assign in_valid  = s_tvalid && s_tready;
    assign in_tag.op = t_opcode'(s_tuser);
    assign in_tag.hit = s_tdata[ADDR_W];

    lhbp_hash_mod u_hash_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (in_valid),
        .i_addr  (s_tdata[ADDR_W-1:0]),
        .i_tag   (in_tag),
        .o_valid (hm_valid),
        .o_idx   (hm_idx),
        .o_tag   (hm_tag)
    );

    // Table write port: sweep first, else training write-back
    assign ram_we    = r_clr_busy || tr_we;
    assign ram_waddr = r_clr_busy ? r_clr_idx : tr_waddr;
    assign ram_wdata = r_clr_busy ? WORD_W'(CTR_RESET) : tr_wdata;

    lhbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (hm_idx),
        .o_rdata (ram_rdata)
    );

    lhbp_train #(
        .HISTORY_BITS  (HISTORY_BITS)
    ) u_train (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_enable    (r_enable),
        .i_valid     (hm_valid),
        .i_idx       (hm_idx),
        .i_tag       (hm_tag),
        .i_rdata     (ram_rdata),
        .o_we        (tr_we),
        .o_waddr     (tr_waddr),
        .o_wdata     (tr_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lhbp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_res    (res),
        .o_adv    (adv),
        .o_stat   (obuf_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // No request may enter during the sweep
    `LHBP_ASSERT_IMPLIES(a_no_accept_clr, i_clk, i_rst_n, r_clr_busy, !s_tready)
    // Training never writes while the sweep owns the write port
    `LHBP_ASSERT_IMPLIES(a_no_train_clr, i_clk, i_rst_n, tr_we, !r_clr_busy)
    // The skid entry only fills behind a held output
    `LHBP_ASSERT_IMPLIES(a_skid_behind, i_clk, i_rst_n, obuf_stat.skid_valid, obuf_stat.out_valid)
    // A taken output drains the skid entry
    `LHBP_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, obuf_stat.skid_valid && m_tready, !obuf_stat.skid_valid)

endmodule

@@ rtl/lhbp_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lhbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lhbp_hash_mod.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_hash_mod
// Input register: address hash reduced to a table index. The table size is
// a power of two, so the reduction keeps the low hash bits.
// ---------------------------------------------------------------------------
module lhbp_hash_mod
    import lhbp_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic [ADDR_W-1:0]                i_addr,
    input  t_tag                             i_tag,
    output logic                             o_valid,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_idx,
    output t_tag                             o_tag
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic          r_vld;
    logic [IW-1:0] r_idx;
    t_tag          r_tag;
    logic [IW-1:0] idx;

    // Low bits of addr ^ (addr >> HASH_SHIFT)
    assign idx = i_addr[IW-1:0] ^ i_addr[HASH_SHIFT +: IW];

    // Advance the valid bit with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
        end
    end

    // Capture the index and the side band
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx <= idx;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_vld;
    assign o_idx   = r_idx;
    assign o_tag   = r_tag;

endmodule

@@ rtl/lhbp_train.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_train
// Entry update stage: counter training, history shift, prediction and
// write-back, with forwarding between back-to-back requests to one entry.
// ---------------------------------------------------------------------------
module lhbp_train
    import lhbp_pkg::*;
#(
    parameter int HISTORY_BITS  = DEF_HISTORY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_enable,
    input  logic                             i_valid,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_idx,
    input  t_tag                             i_tag,
    input  logic [HISTORY_BITS+1:0]          i_rdata,
    output logic                             o_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_waddr,
    output logic [HISTORY_BITS+1:0]          o_wdata,
    output logic                             o_res_valid,
    output t_result                          o_res
);

    localparam int IW     = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = HISTORY_BITS + 2;

    logic                    r_x_vld;
    logic [IW-1:0]           r_x_idx;
    t_tag                    r_x_tag;
    logic                    r_fwd;
    logic [WORD_W-1:0]       r_fwd_word;

    logic [WORD_W-1:0]       cur_word;
    logic [1:0]              cur_cnt;
    logic [HISTORY_BITS-1:0] cur_hist;
    logic [1:0]              upd_cnt;
    logic [HISTORY_BITS:0]   shifted;
    logic                    upd;
    logic [WORD_W-1:0]       new_word;
    logic [1:0]              new_cnt;
    logic [HISTORY_BITS-1:0] new_hist;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (i_adv) begin
            r_x_vld <= i_valid;
        end
    end

    // Capture the request; forward this entry's value if the next one matches
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x_idx    <= i_idx;
            r_x_tag    <= i_tag;
            r_fwd      <= r_x_vld && (r_x_idx == i_idx);
            r_fwd_word <= new_word;
        end
    end

    // Pick the up-to-date entry
    assign cur_word = r_fwd ? r_fwd_word : i_rdata;
    assign cur_cnt  = cur_word[1:0];
    assign cur_hist = cur_word[WORD_W-1:2];

    // Saturating counter step
    always_comb begin
        upd_cnt = cur_cnt;
        if (r_x_tag.hit) begin
            if (cur_cnt != CTR_MAX) begin
                upd_cnt = cur_cnt + 2'd1;
            end
        end else begin
            if (cur_cnt != CTR_MIN) begin
                upd_cnt = cur_cnt - 2'd1;
            end
        end
    end

    // Shift the outcome in, drop the oldest bit
    assign shifted  = {cur_hist, r_x_tag.hit};
    assign upd      = i_enable && (r_x_tag.op == OP_UPDATE);
    assign new_cnt  = upd ? upd_cnt : cur_cnt;
    assign new_hist = upd ? shifted[HISTORY_BITS-1:0] : cur_hist;
    assign new_word = {new_hist, new_cnt};

    assign o_we    = i_adv && r_x_vld && upd;
    assign o_waddr = r_x_idx;
    assign o_wdata = new_word;

    assign o_res_valid = r_x_vld;
    assign o_res.pred  = i_enable && (new_cnt >= CTR_HIT_THR);
    assign o_res.hist  = HIST_OUT_W'(new_hist);

endmodule

@@ rtl/lhbp_out_buf.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_out_buf
// Output register with one skid entry; the pipeline advances while the
// skid entry is free.
// ---------------------------------------------------------------------------
module lhbp_out_buf
    import lhbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_result              i_res,
    output logic                 o_adv,
    output t_obuf_stat           o_stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out_res;
    t_result r_skid_res;
    logic    take;

    assign take = r_out_vld && m_tready;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    // Hold, refill from the skid entry, or take the new result
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_res <= r_skid_res;
            end
        end else if (i_valid) begin
            if (!r_out_vld || take) begin
                r_out_res <= i_res;
            end else begin
                r_skid_res <= i_res;
            end
        end
    end

    assign o_adv             = !r_skid_vld;
    assign o_stat.out_valid  = r_out_vld;
    assign o_stat.skid_valid = r_skid_vld;
    assign m_tvalid          = r_out_vld;
    assign m_tdata           = M_TDATA_W'(r_out_res);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the load-hit bimodal predictor. Requests go in
// through the slave stream with random gaps. Results come back through the
// master stream under random back-pressure. Each request is run against a
// mirror of the counter and history tables, and every result is compared
// field by field with the oldest outstanding prediction. The enable
// register is toggled between phases, only while the block is drained.
// ---------------------------------------------------------------------------
module tb;
    import lhbp_pkg::*;

    localparam int          HISTORY_BITS   = DEF_HISTORY_BITS;
    localparam logic [HIST_OUT_W-1:0] HIST_MASK = HIST_OUT_W'((1 << HISTORY_BITS) - 1);
    localparam int          PIPE_LATENCY   = 2;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOT_ENTRIES    = 16;

    typedef struct {
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              drain_first;   // hold until every result is back
    } t_request;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wen   = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [63:0] load_address, [64] actual_hit
    logic                 s_tuser     = 1'b0; // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready    = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;            // [0] predict_hit, [8:1] entry_history

    // Mirror of the block's tables and register
    logic [1:0]            ctr_mirror  [TABLE_ENTRIES];
    logic [HIST_OUT_W-1:0] hist_mirror [TABLE_ENTRIES];
    logic                  enable_mirror;

    t_request pending_requests[$];
    t_result  expected_results[$];
    t_request active_req;

    logic [ADDR_W-1:0] hot_addr [HOT_ENTRIES];
    logic              hot_bias [HOT_ENTRIES];

    int unsigned src_pause  = 0;
    int unsigned src_quiet  = 0;
    int unsigned sink_stall = 0;
    int unsigned sink_quiet = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;
    logic        send_next;
    logic        ready_next;
    t_result     got_result;
    t_result     want_result;

    load_hit_bimodal_predictor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Apply one request to the mirror tables and return the result it yields
    function automatic t_result train_and_lookup(t_request req);
        int unsigned idx;
        logic [1:0]  ctr;
        t_result     res;
        idx = 32'((req.addr ^ (req.addr >> HASH_SHIFT)) % TABLE_ENTRIES);
        if (enable_mirror && req.op == OP_UPDATE) begin
            hist_mirror[idx] = ((hist_mirror[idx] << 1) | req.hit) & HIST_MASK;
            ctr = ctr_mirror[idx];
            if (req.hit) begin
                if (ctr != CTR_MAX) ctr = ctr + 2'd1;
            end else if (ctr != CTR_MIN) begin
                ctr = ctr - 2'd1;
            end
            ctr_mirror[idx] = ctr;
        end
        res.pred = enable_mirror && (ctr_mirror[idx] >= CTR_HIT_THR);
        res.hist = hist_mirror[idx];
        return res;
    endfunction

    // Mostly short pauses, a few long ones, and now and then a quiet stretch
    function automatic int unsigned draw_pause(inout int unsigned quiet_left);
        int unsigned r;
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Driver: present queued requests, predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_pause = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(train_and_lookup(active_req));
                src_pause = draw_pause(src_quiet);
            end
            if (!s_tvalid || s_tready) begin
                send_next = 1'b0;
                if (src_pause != 0) begin
                    src_pause--;
                end else if (pending_requests.size() != 0 &&
                             (!pending_requests[0].drain_first ||
                              expected_results.size() == 0)) begin
                    active_req = pending_requests.pop_front();
                    send_next  = 1'b1;
                end
                s_tvalid <= send_next;
                s_tdata  <= {{(S_TDATA_W - ADDR_W - 1){1'b0}}, active_req.hit, active_req.addr};
                s_tuser  <= active_req.op;
            end
        end
    end

    // Monitor: check each accepted result, then pick the next ready level
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result = t_result'(m_tdata[$bits(t_result)-1:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing outstanding: expected none actual %h",
                             $time, got_result);
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.pred !== want_result.pred) begin
                        $display("%0t: predict_hit mismatch: expected %0b actual %0b",
                                 $time, want_result.pred, got_result.pred);
                        fail_count++;
                    end
                    if (got_result.hist !== want_result.hist) begin
                        $display("%0t: entry_history mismatch: expected %h actual %h",
                                 $time, want_result.hist, got_result.hist);
                        fail_count++;
                    end
                end
            end
            if (sink_stall == 0) sink_stall = draw_pause(sink_quiet);
            ready_next = 1'b1;
            if (sink_stall != 0) begin
                sink_stall--;
                ready_next = 1'b0;
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog: give up when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL load_hit_bimodal_predictor");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_request(input t_opcode op, input logic [ADDR_W-1:0] addr,
                                 input logic hit, input logic drain_first = 1'b0);
        t_request req;
        req.op          = op;
        req.addr        = addr;
        req.hit         = hit;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // Wait until every request is sent and every result is back, then let
    // the pipeline run empty
    task automatic drain_block();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        enable_mirror = value;
    endtask

    // Random traffic: mostly training on a few hot entries and their aliases,
    // the rest scattered over the whole address space
    task automatic queue_random(input int count, input int drain_at);
        int                k;
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] fold;
        logic              hit;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < 60) ? OP_UPDATE : OP_PREDICT;
            if ($urandom_range(0, 99) < 70) begin
                k    = $urandom_range(0, HOT_ENTRIES - 1);
                addr = hot_addr[k];
                case ($urandom_range(0, 3))
                    0: addr = addr ^ ({$urandom(), $urandom()} & ~64'hF_FFFF);
                    1: begin
                        fold = 64'($urandom_range(0, TABLE_ENTRIES - 1));
                        addr = addr ^ (fold | (fold << HASH_SHIFT));
                    end
                    default: ;
                endcase
                hit = ($urandom_range(0, 99) < 80) ? hot_bias[k] : 1'($urandom_range(0, 1));
                // flip the trend now and then so counters sweep both ways
                if ($urandom_range(0, 49) == 0) hot_bias[k] = ~hot_bias[k];
            end else begin
                addr = {$urandom(), $urandom()};
                hit  = 1'($urandom_range(0, 1));
            end
            queue_request(op, addr, hit, n == drain_at);
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            ctr_mirror[i]  = CTR_RESET;
            hist_mirror[i] = '0;
        end
        enable_mirror = 1'b1;
        for (int i = 0; i < HOT_ENTRIES; i++) begin
            hot_addr[i] = {$urandom(), $urandom()};
            hot_bias[i] = 1'($urandom_range(0, 1));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_enable(1'b1);

        // Enabled: reset state, both saturation ends, history wrap, aliasing
        @(negedge i_clk);
        queue_request(OP_PREDICT, 64'h0, 1'b0);
        queue_request(OP_PREDICT, '1, 1'b0);
        repeat (3) queue_request(OP_UPDATE, 64'h0, 1'b0);
        repeat (4) queue_request(OP_UPDATE, 64'h0, 1'b1);
        queue_request(OP_PREDICT, 64'h0, 1'b1);
        queue_request(OP_UPDATE, 64'h0, 1'b0);
        queue_request(OP_PREDICT, 64'hFFFF_FFFF_FFF0_0000, 1'b0);
        queue_request(OP_UPDATE, 64'hFFFF_FFFF_FFF0_0000, 1'b1);
        queue_request(OP_UPDATE, '1, 1'b1);
        queue_request(OP_UPDATE, 64'h8000_0000_0000_0000, 1'b1);
        drain_block();

        // Disabled: predictions answer miss and updates leave tables alone
        write_enable(1'b0);
        @(negedge i_clk);
        queue_request(OP_PREDICT, 64'h0, 1'b0);
        queue_request(OP_UPDATE, 64'h0, 1'b1);
        queue_request(OP_UPDATE, '1, 1'b0);
        queue_request(OP_PREDICT, '1, 1'b1);
        drain_block();

        // Enabled again: stored state must be as before the disabled phase
        write_enable(1'b1);
        @(negedge i_clk);
        queue_request(OP_PREDICT, 64'h0, 1'b0);
        queue_request(OP_PREDICT, '1, 1'b0);
        drain_block();

        @(negedge i_clk);
        queue_random(650, 300);
        drain_block();
        write_enable(1'b0);
        @(negedge i_clk);
        queue_random(300, -1);
        drain_block();
        write_enable(1'b1);
        @(negedge i_clk);
        queue_random(700, -1);
        drain_block();

        if (fail_count == 0) begin
            $display("PASS load_hit_bimodal_predictor");
        end else begin
            $display("FAIL load_hit_bimodal_predictor");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lhbp_pkg.sv
rtl/lhbp_ram.sv
rtl/lhbp_hash_mod.sv
rtl/lhbp_train.sv
rtl/lhbp_out_buf.sv
rtl/load_hit_bimodal_predictor.sv
dv/tb.sv
